### hdl/vbi2d_pkg.sv
// Package for the 2D Verlet body integrator: fixed-point constants, control codes,
// the microword layout and the microprogram held as a read-only table.
// It depends on nothing else.
`default_nettype none

package vbi2d_pkg;

  localparam int FracBits = 16;
  localparam int DtBits   = 16;
  localparam int DataW    = 32;
  localparam int StepW    = 16;
  localparam int OpaW     = DataW + 1;
  localparam int ProdW    = 2 * OpaW;
  localparam int WideW    = ProdW + 2;
  localparam int PcW      = 5;
  localparam int ProgLen  = 22;

  localparam logic [DataW-1:0] InvMassRst    = 32'd65536;
  localparam logic [DataW-1:0] InvInertiaRst = 32'd65536;
  localparam logic [StepW-1:0] StepTimeRst   = 16'd1092;
  localparam logic [DataW-1:0] InvStepRst    = 32'd3932160;

  typedef enum logic [2:0] {
    ACT_FORCE,
    ACT_TORQUE,
    ACT_INTEGRATE,
    ACT_SET_VEL,
    ACT_SET_ANG_VEL,
    ACT_LOAD_POSE
  } action_e;

  typedef enum logic [2:0] {
    CFG_INV_MASS,
    CFG_INV_INERTIA,
    CFG_STEP_TIME,
    CFG_INV_STEP_TIME,
    CFG_SIMULATED,
    CFG_KINEMATIC
  } cfg_idx_e;

  typedef enum logic [1:0] {AX_X, AX_Y, AX_R} axis_e;
  typedef enum logic [1:0] {OPA_VAL, OPA_ACC, OPA_DIFF, OPA_STEP} opa_e;
  typedef enum logic [2:0] {
    OPB_INV_MASS, OPB_INV_INERTIA, OPB_STEP, OPB_DT2, OPB_INV_STEP
  } opb_e;
  typedef enum logic [1:0] {SH_FRAC, SH_DT, SH_DT2, SH_NONE} shift_e;
  typedef enum logic [2:0] {
    WB_NONE, WB_DT2, WB_ACC, WB_VERLET, WB_OLD, WB_LOAD, WB_KIN, WB_VEL
  } wb_e;
  typedef enum logic [1:0] {SQ_NEXT, SQ_JUMP, SQ_INT, SQ_DONE} seq_e;

  typedef struct packed {
    opa_e            a_sel;
    opb_e            b_sel;
    axis_e           m_ax;
    shift_e          sh;
    wb_e             wb;
    axis_e           w_ax;
    seq_e            seq;
    logic [PcW-1:0]  target;
  } uword_t;

  localparam logic [PcW-1:0] UpcVel0   = 5'd0;
  localparam logic [PcW-1:0] UpcVel1   = 5'd1;
  localparam logic [PcW-1:0] UpcForce  = 5'd4;
  localparam logic [PcW-1:0] UpcTorque = 5'd7;
  localparam logic [PcW-1:0] UpcInt    = 5'd9;
  localparam logic [PcW-1:0] UpcKin    = 5'd15;
  localparam logic [PcW-1:0] UpcSetVel = 5'd16;
  localparam logic [PcW-1:0] UpcSetAng = 5'd19;
  localparam logic [PcW-1:0] UpcLoad   = 5'd21;

  function automatic uword_t uw(opa_e a, opb_e b, axis_e max, shift_e sh, wb_e wb,
                                axis_e wax, seq_e sq, logic [PcW-1:0] tgt);
    uword_t w;
    w.a_sel  = a;
    w.b_sel  = b;
    w.m_ax   = max;
    w.sh     = sh;
    w.wb     = wb;
    w.w_ax   = wax;
    w.seq    = sq;
    w.target = tgt;
    return w;
  endfunction

  // Each word issues one multiply and retires the product of the previous word.
  function automatic uword_t ucode(logic [PcW-1:0] pc);
    uword_t w;
    case (pc)
      5'd0:  w = uw(OPA_DIFF, OPB_INV_STEP, AX_X, SH_FRAC, WB_NONE, AX_X, SQ_NEXT, UpcVel0);
      5'd1:  w = uw(OPA_DIFF, OPB_INV_STEP, AX_Y, SH_FRAC, WB_VEL, AX_X, SQ_NEXT, UpcVel0);
      5'd2:  w = uw(OPA_DIFF, OPB_INV_STEP, AX_R, SH_FRAC, WB_VEL, AX_Y, SQ_NEXT, UpcVel0);
      5'd3:  w = uw(OPA_DIFF, OPB_INV_STEP, AX_R, SH_FRAC, WB_VEL, AX_R, SQ_DONE, UpcVel0);
      5'd4:  w = uw(OPA_VAL, OPB_INV_MASS, AX_X, SH_FRAC, WB_NONE, AX_X, SQ_NEXT, UpcVel0);
      5'd5:  w = uw(OPA_VAL, OPB_INV_MASS, AX_Y, SH_FRAC, WB_ACC, AX_X, SQ_NEXT, UpcVel0);
      5'd6:  w = uw(OPA_DIFF, OPB_INV_STEP, AX_X, SH_FRAC, WB_ACC, AX_Y, SQ_JUMP, UpcVel1);
      5'd7:  w = uw(OPA_VAL, OPB_INV_INERTIA, AX_R, SH_FRAC, WB_NONE, AX_R, SQ_NEXT, UpcVel0);
      5'd8:  w = uw(OPA_DIFF, OPB_INV_STEP, AX_X, SH_FRAC, WB_ACC, AX_R, SQ_JUMP, UpcVel1);
      5'd9:  w = uw(OPA_STEP, OPB_STEP, AX_X, SH_NONE, WB_NONE, AX_X, SQ_INT, UpcKin);
      5'd10: w = uw(OPA_STEP, OPB_STEP, AX_X, SH_NONE, WB_DT2, AX_X, SQ_NEXT, UpcVel0);
      5'd11: w = uw(OPA_ACC, OPB_DT2, AX_X, SH_DT2, WB_NONE, AX_X, SQ_NEXT, UpcVel0);
      5'd12: w = uw(OPA_ACC, OPB_DT2, AX_Y, SH_DT2, WB_VERLET, AX_X, SQ_NEXT, UpcVel0);
      5'd13: w = uw(OPA_ACC, OPB_DT2, AX_R, SH_DT2, WB_VERLET, AX_Y, SQ_NEXT, UpcVel0);
      5'd14: w = uw(OPA_DIFF, OPB_INV_STEP, AX_X, SH_FRAC, WB_VERLET, AX_R, SQ_JUMP, UpcVel1);
      5'd15: w = uw(OPA_DIFF, OPB_INV_STEP, AX_X, SH_FRAC, WB_KIN, AX_X, SQ_JUMP, UpcVel0);
      5'd16: w = uw(OPA_VAL, OPB_STEP, AX_X, SH_DT, WB_NONE, AX_X, SQ_NEXT, UpcVel0);
      5'd17: w = uw(OPA_VAL, OPB_STEP, AX_Y, SH_DT, WB_OLD, AX_X, SQ_NEXT, UpcVel0);
      5'd18: w = uw(OPA_DIFF, OPB_INV_STEP, AX_X, SH_FRAC, WB_OLD, AX_Y, SQ_JUMP, UpcVel1);
      5'd19: w = uw(OPA_VAL, OPB_STEP, AX_R, SH_DT, WB_NONE, AX_R, SQ_NEXT, UpcVel0);
      5'd20: w = uw(OPA_DIFF, OPB_INV_STEP, AX_X, SH_FRAC, WB_OLD, AX_R, SQ_JUMP, UpcVel1);
      5'd21: w = uw(OPA_DIFF, OPB_INV_STEP, AX_X, SH_FRAC, WB_LOAD, AX_X, SQ_JUMP, UpcVel0);
      default: w = uw(OPA_DIFF, OPB_INV_STEP, AX_X, SH_FRAC, WB_NONE, AX_X, SQ_JUMP, UpcVel0);
    endcase
    return w;
  endfunction

  function automatic logic [PcW-1:0] entry_pc(logic [2:0] action);
    logic [PcW-1:0] pc;
    case (action)
      ACT_FORCE:       pc = UpcForce;
      ACT_TORQUE:      pc = UpcTorque;
      ACT_INTEGRATE:   pc = UpcInt;
      ACT_SET_VEL:     pc = UpcSetVel;
      ACT_SET_ANG_VEL: pc = UpcSetAng;
      ACT_LOAD_POSE:   pc = UpcLoad;
      default:         pc = UpcVel0;
    endcase
    return pc;
  endfunction

  function automatic logic signed [DataW-1:0] sat32(logic signed [WideW-1:0] v);
    logic signed [DataW-1:0] r;
    if (!v[WideW-1] && (|v[WideW-2:DataW-1])) begin
      r = 32'sh7fffffff;
    end else if (v[WideW-1] && !(&v[WideW-2:DataW-1])) begin
      r = 32'sh80000000;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/verlet_body_integrator_2d_unit.sv
// A new beat is taken only while no item runs: in_stall_o stays high until the microprogram ends.
// One 33x32 multiplier, one product per step; the last step waits while a result is stalled.
// A microprogram of 22 words steps the shared multiplier and the write-back path.
// Reset loads the register defaults and clears the pose, previous pose and accumulators.
// Depends on vbi2d_pkg.
`default_nettype none

module verlet_body_integrator_2d_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         action_i,
  input  wire logic signed [31:0] value_x_i,
  input  wire logic signed [31:0] value_y_i,
  input  wire logic signed [31:0] value_r_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic signed [31:0]      rot_o,
  output logic signed [31:0]      vel_x_o,
  output logic signed [31:0]      vel_y_o,
  output logic signed [31:0]      ang_vel_o,
  output logic                    pose_changed_o
);
  import vbi2d_pkg::*;

  logic [DataW-1:0] inv_mass_q, inv_inertia_q, inv_step_q;
  logic [StepW-1:0] step_q;
  logic             simulated_q, kinematic_q;

  logic signed [DataW-1:0] cur_x_q, cur_y_q, cur_r_q, cur_x_d, cur_y_d, cur_r_d;
  logic signed [DataW-1:0] old_x_q, old_y_q, old_r_q, old_x_d, old_y_d, old_r_d;
  logic signed [DataW-1:0] acc_x_q, acc_y_q, acc_r_q, acc_x_d, acc_y_d, acc_r_d;
  logic signed [DataW-1:0] val_x_q, val_y_q, val_r_q;
  logic signed [DataW-1:0] vel_x_q, vel_y_q, vel_x_d, vel_y_d;
  logic [DataW-1:0]        dt2_q, dt2_d;
  logic                    changed_q, changed_d;

  logic                    run_q, run_d;
  logic [PcW-1:0]          pc_q, pc_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  shift_e                  sh_q;
  logic                    out_valid_q, out_valid_d;

  uword_t                  uw_c;
  logic                    in_acc, step_en, done_en;
  logic signed [DataW-1:0] val_m, acc_m, cur_m, old_m, cur_ws, old_ws, acc_ws;
  logic signed [OpaW-1:0]  opa;
  logic [DataW-1:0]        opb;
  logic signed [ProdW-1:0] sh_val;
  logic signed [WideW-1:0] sh_ext, cur_w, old_w, acc_w;
  logic signed [DataW-1:0] acc_new, vrl_new, old_new, vel_new;

  assign uw_c    = ucode(pc_q);
  assign in_acc  = in_valid_i && !run_q;
  assign done_en = run_q && (uw_c.seq == SQ_DONE);
  assign step_en = run_q && !(uw_c.seq == SQ_DONE && out_valid_q && out_stall_i);

  always_comb begin
    case (uw_c.m_ax)
      AX_X: begin
        val_m = val_x_q; acc_m = acc_x_q; cur_m = cur_x_q; old_m = old_x_q;
      end
      AX_Y: begin
        val_m = val_y_q; acc_m = acc_y_q; cur_m = cur_y_q; old_m = old_y_q;
      end
      default: begin
        val_m = val_r_q; acc_m = acc_r_q; cur_m = cur_r_q; old_m = old_r_q;
      end
    endcase
    case (uw_c.a_sel)
      OPA_VAL:  opa = $signed({val_m[DataW-1], val_m});
      OPA_ACC:  opa = $signed({acc_m[DataW-1], acc_m});
      OPA_DIFF: opa = $signed({cur_m[DataW-1], cur_m}) - $signed({old_m[DataW-1], old_m});
      default:  opa = $signed({{(OpaW-StepW){1'b0}}, step_q});
    endcase
    case (uw_c.b_sel)
      OPB_INV_MASS:    opb = inv_mass_q;
      OPB_INV_INERTIA: opb = inv_inertia_q;
      OPB_STEP:        opb = {{(DataW-StepW){1'b0}}, step_q};
      OPB_DT2:         opb = dt2_q;
      default:         opb = inv_step_q;
    endcase
  end

  assign prod_d = opa * $signed({1'b0, opb});

  always_comb begin
    case (sh_q)
      SH_FRAC: sh_val = prod_q >>> FracBits;
      SH_DT:   sh_val = prod_q >>> DtBits;
      SH_DT2:  sh_val = prod_q >>> (2 * DtBits);
      default: sh_val = prod_q;
    endcase
    sh_ext = $signed({{(WideW-ProdW){sh_val[ProdW-1]}}, sh_val});
    case (uw_c.w_ax)
      AX_X:    begin cur_ws = cur_x_q; old_ws = old_x_q; acc_ws = acc_x_q; end
      AX_Y:    begin cur_ws = cur_y_q; old_ws = old_y_q; acc_ws = acc_y_q; end
      default: begin cur_ws = cur_r_q; old_ws = old_r_q; acc_ws = acc_r_q; end
    endcase
    cur_w   = $signed({{(WideW-DataW){cur_ws[DataW-1]}}, cur_ws});
    old_w   = $signed({{(WideW-DataW){old_ws[DataW-1]}}, old_ws});
    acc_w   = $signed({{(WideW-DataW){acc_ws[DataW-1]}}, acc_ws});
    acc_new = sat32(acc_w + sh_ext);
    vrl_new = sat32(cur_w + cur_w - old_w + sh_ext);
    old_new = sat32(cur_w - sh_ext);
    vel_new = sat32(sh_ext);
  end

  always_comb begin
    cur_x_d = cur_x_q; cur_y_d = cur_y_q; cur_r_d = cur_r_q;
    old_x_d = old_x_q; old_y_d = old_y_q; old_r_d = old_r_q;
    acc_x_d = acc_x_q; acc_y_d = acc_y_q; acc_r_d = acc_r_q;
    vel_x_d = vel_x_q; vel_y_d = vel_y_q;
    dt2_d   = dt2_q;
    changed_d = in_acc ? 1'b0 : changed_q;
    if (step_en) begin
      case (uw_c.wb)
        WB_DT2: dt2_d = prod_q[DataW-1:0];
        WB_ACC: begin
          case (uw_c.w_ax)
            AX_X:    acc_x_d = acc_new;
            AX_Y:    acc_y_d = acc_new;
            default: acc_r_d = acc_new;
          endcase
        end
        WB_VERLET: begin
          case (uw_c.w_ax)
            AX_X: begin
              old_x_d = cur_x_q; cur_x_d = vrl_new; changed_d = 1'b1;
            end
            AX_Y: begin
              old_y_d = cur_y_q; cur_y_d = vrl_new;
            end
            default: begin
              old_r_d = cur_r_q; cur_r_d = vrl_new;
              acc_x_d = '0; acc_y_d = '0; acc_r_d = '0;
            end
          endcase
        end
        WB_OLD: begin
          case (uw_c.w_ax)
            AX_X:    old_x_d = old_new;
            AX_Y:    old_y_d = old_new;
            default: old_r_d = old_new;
          endcase
        end
        WB_LOAD: begin
          cur_x_d = val_x_q; cur_y_d = val_y_q; cur_r_d = val_r_q;
        end
        WB_KIN: begin
          old_x_d = cur_x_q; old_y_d = cur_y_q; old_r_d = cur_r_q;
          acc_x_d = '0; acc_y_d = '0; acc_r_d = '0;
        end
        WB_VEL: begin
          case (uw_c.w_ax)
            AX_X:    vel_x_d = vel_new;
            AX_Y:    vel_y_d = vel_new;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    pc_d  = pc_q;
    run_d = run_q;
    if (in_acc) begin
      pc_d  = entry_pc(action_i);
      run_d = 1'b1;
    end else if (step_en) begin
      case (uw_c.seq)
        SQ_NEXT: pc_d = pc_q + 1'b1;
        SQ_JUMP: pc_d = uw_c.target;
        SQ_INT: begin
          if (!simulated_q) begin
            pc_d = UpcVel0;
          end else if (kinematic_q) begin
            pc_d = uw_c.target;
          end else begin
            pc_d = pc_q + 1'b1;
          end
        end
        default: run_d = 1'b0;
      endcase
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (done_en && step_en) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_mass_q    <= InvMassRst;
      inv_inertia_q <= InvInertiaRst;
      step_q        <= StepTimeRst;
      inv_step_q    <= InvStepRst;
      simulated_q   <= 1'b1;
      kinematic_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INV_MASS:      inv_mass_q    <= cfg_wdata_i;
        CFG_INV_INERTIA:   inv_inertia_q <= cfg_wdata_i;
        CFG_STEP_TIME:     step_q        <= cfg_wdata_i[StepW-1:0];
        CFG_INV_STEP_TIME: inv_step_q    <= cfg_wdata_i;
        CFG_SIMULATED:     simulated_q   <= cfg_wdata_i[0];
        CFG_KINEMATIC:     kinematic_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0; cur_y_q <= '0; cur_r_q <= '0;
      old_x_q <= '0; old_y_q <= '0; old_r_q <= '0;
      acc_x_q <= '0; acc_y_q <= '0; acc_r_q <= '0;
      run_q       <= 1'b0;
      pc_q        <= UpcVel0;
      out_valid_q <= 1'b0;
      changed_q   <= 1'b0;
    end else begin
      cur_x_q <= cur_x_d; cur_y_q <= cur_y_d; cur_r_q <= cur_r_d;
      old_x_q <= old_x_d; old_y_q <= old_y_d; old_r_q <= old_r_d;
      acc_x_q <= acc_x_d; acc_y_q <= acc_y_d; acc_r_q <= acc_r_d;
      run_q       <= run_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      changed_q   <= changed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vel_x_q <= vel_x_d;
    vel_y_q <= vel_y_d;
    dt2_q   <= dt2_d;
    if (in_acc) begin
      val_x_q <= value_x_i;
      val_y_q <= value_y_i;
      val_r_q <= value_r_i;
    end
    if (step_en) begin
      prod_q <= prod_d;
      sh_q   <= uw_c.sh;
    end
    if (done_en && step_en) begin
      pos_x_o        <= cur_x_q;
      pos_y_o        <= cur_y_q;
      rot_o          <= cur_r_q;
      vel_x_o        <= vel_x_q;
      vel_y_o        <= vel_y_q;
      ang_vel_o      <= vel_new;
      pose_changed_o <= changed_q;
    end
  end

  assign in_stall_o  = run_q;
  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (pc_q < PcW'(ProgLen)))
    else $error("sequencer left the microprogram");

  a_changed_only_dynamic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(changed_q) |-> $past(simulated_q && !kinematic_q))
    else $error("pose marked changed for a body that cannot move");

  a_result_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(run_q))
    else $error("result beat raised without a running item");

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> run_q)
    else $error("accepted beat did not start the sequencer");
`endif

endmodule

`default_nettype wire
